>>> rtl/core/pid_step_with_integrator_clamp_unit_assert.svh
// ----------------------------------------------------------------------------
// pid step assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PID_STEP_WITH_INTEGRATOR_CLAMP_UNIT_ASSERT_SVH
`define PID_STEP_WITH_INTEGRATOR_CLAMP_UNIT_ASSERT_SVH

// same-cycle implication
`define PIDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// shared codes, constants and control structs of the pid step block
// ----------------------------------------------------------------------------
package pidc_pkg;

  // multiplier digit, bits of the multiplier consumed per cycle
  localparam int DIG_BITS = 4;

  // configuration register index width
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP       = 3'd0,
    REG_KI       = 3'd1,
    REG_KD       = 3'd2,
    REG_INTEG_ON = 3'd3,
    REG_LIMIT    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HIGH = 2'd1,
    ST_LOW  = 2'd2
  } clamp_stat_t;

  typedef enum logic {
    OP_STEP  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  // launch control into the multiplier
  typedef struct packed {
    logic start;
    logic b_signed;
  } mul_ctl_t;

  // launch control into the divider
  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

  // status back from an arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> rtl/core/pidc_if.sv
// ----------------------------------------------------------------------------
// pidc_if
// valid/ready channels for pid step requests and results
// ----------------------------------------------------------------------------

// request channel
interface pidc_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic signed [DATA_WIDTH-1:0] error_value;
  logic        [DATA_WIDTH-1:0] time_step;

  modport source (output valid, operation, error_value, time_step, input ready);
  modport sink   (input valid, operation, error_value, time_step, output ready);
endinterface

// result channel
interface pidc_out_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] drive_value;
  logic        [1:0]            integral_status;

  modport source (output valid, drive_value, integral_status, input ready);
  modport sink   (input valid, drive_value, integral_status, output ready);
endinterface

>>> rtl/core/pidc_mul.sv
// ----------------------------------------------------------------------------
// pidc_mul
// digit-serial fixed-point multiplier, one multiplier digit per cycle,
// product shifted down by the fraction bits and saturated
// ----------------------------------------------------------------------------
`include "pid_step_with_integrator_clamp_unit_assert.svh"

module pidc_mul
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mul_ctl_t                     ctl,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic        [DATA_WIDTH-1:0] b,
  output unit_stat_t                   stat,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int W     = DATA_WIDTH;
  localparam int STEPS = (W + DIG_BITS - 1) / DIG_BITS;
  localparam int MB    = STEPS * DIG_BITS;
  localparam int PW    = W + MB;
  localparam int CW    = $clog2(STEPS);

  localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_FIN
  } mstate_t;

  mstate_t              state_r;
  logic [CW-1:0]        cnt_r;
  logic [W-1:0]         a_mag_r;
  logic [MB-1:0]        b_sh_r;
  logic [PW-1:0]        p_r;
  logic                 neg_r;
  logic                 done_r;
  logic signed [W-1:0]  result_r;

  logic [W-1:0]           a_mag;
  logic [W-1:0]           b_mag;
  logic [W+DIG_BITS-1:0]  pp;
  logic [W+DIG_BITS-1:0]  acc_sum;
  logic [PW-1:0]          p_nxt;
  logic [PW-1:0]          m_full;
  logic                   over;
  logic signed [W-1:0]    sat_res;

  // saturate a magnitude with sign to the signed word range
  function automatic logic signed [W-1:0] sat_mag(input logic neg, input logic ovf,
                                                  input logic [W-1:0] m);
    logic signed [W-1:0] r;
    if (!neg) begin
      r = (ovf || m[W-1]) ? MAX_V : $signed(m);
    end else begin
      r = (ovf || (m[W-1] && (m[W-2:0] != '0))) ? MIN_V : $signed(-m);
    end
    return r;
  endfunction

  // operand magnitudes at launch
  assign a_mag = a[W-1] ? W'(-a) : W'(a);
  assign b_mag = (ctl.b_signed && b[W-1]) ? W'(-b) : b;

  // one digit of partial product folded into the upper accumulator
  assign pp      = (W+DIG_BITS)'(a_mag_r) * (W+DIG_BITS)'(b_sh_r[DIG_BITS-1:0]);
  assign acc_sum = (W+DIG_BITS)'(p_r[PW-1:MB]) + pp;
  assign p_nxt   = {acc_sum, p_r[MB-1:DIG_BITS]};

  // drop the fraction bits and clip
  assign m_full  = p_r >> FRAC_BITS;
  assign over    = (m_full >> W) != '0;
  assign sat_res = sat_mag(neg_r, over, m_full[W-1:0]);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (ctl.start) begin
            a_mag_r <= a_mag;
            b_sh_r  <= MB'(b_mag);
            p_r     <= '0;
            neg_r   <= a[W-1] ^ (ctl.b_signed & b[W-1]);
            cnt_r   <= CW'(STEPS - 1);
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          p_r    <= p_nxt;
          b_sh_r <= b_sh_r >> DIG_BITS;
          if (cnt_r == '0) begin
            state_r <= M_FIN;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        M_FIN: begin
          result_r <= sat_res;
          done_r   <= 1'b1;
          state_r  <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != M_IDLE);
  assign stat.done = done_r;
  assign result    = result_r;

  `PIDC_ASSERT_NEXT(a_mul_launch, ctl.start, state_r == M_RUN, "multiplier missed a launch")
  `PIDC_ASSERT_NOW(a_mul_pos, done_r && !neg_r, !result_r[W-1], "positive product went negative")
  `PIDC_ASSERT_NOW(a_mul_neg, done_r && neg_r, result_r[W-1] || (result_r == '0),
                   "negative product went positive")

endmodule

>>> rtl/core/pidc_div.sv
// ----------------------------------------------------------------------------
// pidc_div
// bit-serial restoring divider, (num << frac) / den, one quotient bit per
// cycle, signed and saturated result
// ----------------------------------------------------------------------------
`include "pid_step_with_integrator_clamp_unit_assert.svh"

module pidc_div
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  div_ctl_t                     ctl,
  input  logic        [DATA_WIDTH-1:0] num,
  input  logic        [DATA_WIDTH-1:0] den,
  output unit_stat_t                   stat,
  output logic signed [DATA_WIDTH-1:0] result
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = W + FRAC_BITS;
  localparam int CW = $clog2(NW);

  localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } dstate_t;

  dstate_t              state_r;
  logic [CW-1:0]        cnt_r;
  logic [NW-1:0]        n_r;
  logic [W-1:0]         r_r;
  logic [W-1:0]         den_r;
  logic                 neg_r;
  logic                 done_r;
  logic signed [W-1:0]  result_r;

  logic [W:0]           rr;
  logic [W:0]           rr_sub;
  logic                 ge;
  logic [W-1:0]         r_nxt;
  logic                 over;
  logic signed [W-1:0]  sat_res;

  // saturate a magnitude with sign to the signed word range
  function automatic logic signed [W-1:0] sat_mag(input logic neg, input logic ovf,
                                                  input logic [W-1:0] m);
    logic signed [W-1:0] r;
    if (!neg) begin
      r = (ovf || m[W-1]) ? MAX_V : $signed(m);
    end else begin
      r = (ovf || (m[W-1] && (m[W-2:0] != '0))) ? MIN_V : $signed(-m);
    end
    return r;
  endfunction

  // restoring step: bring down one numerator bit, try subtract
  assign rr     = {r_r, n_r[NW-1]};
  assign rr_sub = rr - {1'b0, den_r};
  assign ge     = (rr >= {1'b0, den_r});
  assign r_nxt  = ge ? rr_sub[W-1:0] : rr[W-1:0];

  // quotient clip
  assign over    = (n_r >> W) != '0;
  assign sat_res = sat_mag(neg_r, over, n_r[W-1:0]);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (ctl.start) begin
            n_r     <= NW'(num) << FRAC_BITS;
            r_r     <= '0;
            den_r   <= den;
            neg_r   <= ctl.neg;
            cnt_r   <= CW'(NW - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          r_r <= r_nxt;
          n_r <= {n_r[NW-2:0], ge};
          if (cnt_r == '0) begin
            state_r <= D_FIN;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        D_FIN: begin
          result_r <= sat_res;
          done_r   <= 1'b1;
          state_r  <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign stat.busy = (state_r != D_IDLE);
  assign stat.done = done_r;
  assign result    = result_r;

  `PIDC_ASSERT_NEXT(a_div_launch, ctl.start, state_r == D_RUN, "divider missed a launch")
  `PIDC_ASSERT_NOW(a_div_pos, done_r && !neg_r, !result_r[W-1], "positive quotient went negative")
  `PIDC_ASSERT_NOW(a_div_neg, done_r && neg_r, result_r[W-1] || (result_r == '0),
                   "negative quotient went positive")

endmodule

>>> rtl/core/pid_step_with_integrator_clamp_unit.sv
// ----------------------------------------------------------------------------
// pid_step_with_integrator_clamp_unit
// fixed-point pid step with integrator clamp, shared digit-serial units
// ----------------------------------------------------------------------------
// usage
//   in_chan carries one request per transaction: a clear, or a control step
//   with an error and a time step. out_chan returns exactly one result per
//   request: the saturated drive and the integral clamp status.
//   the user must write gains, integrator enable and clamp limit on cfg_we/
//   cfg_index/cfg_data only while no request is in flight; not enforced.
// sequencing
//   a clear or a zero time step goes from S_LAUNCH straight to S_PUT.
//   a step with a derivative launches the divider beside the multiplier:
//   the divider resolves one quotient bit per cycle, then the derivative
//   gain goes through the 4-bit-per-cycle multiplier. a first step skips
//   the divider, and with the integrator off a step goes straight to kp.
//   one request is worked at a time; the next is taken in the cycle after
//   the result is handed over.
// reset and stall
//   synchronous reset clears gains, limit, stored error, drive and integral
//   and re-arms the first-step flag. the result sits in an output register;
//   while it waits on out_chan.ready the next request is still accepted and
//   worked, and its own result holds until the register frees.
// ----------------------------------------------------------------------------
`include "pid_step_with_integrator_clamp_unit_assert.svh"

module pid_step_with_integrator_clamp_unit
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pidc_in_if.sink               in_chan,
  pidc_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);

  localparam int W = DATA_WIDTH;

  localparam logic signed [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  // error band and sign threshold
  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [W-1:0] BAND_HIGH = W'(ONE_Q);
  localparam logic [W-1:0] BAND_LOW  = W'((ONE_Q * 5 + 99) / 100);
  localparam logic [W-1:0] EPS_Q     = W'(ONE_Q / 1000000);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAUNCH,
    S_EDT,
    S_KI,
    S_CLAMP,
    S_KP,
    S_WAIT_DIV,
    S_KD,
    S_PUT
  } state_t;

  // configuration
  logic signed [W-1:0] kp_r, ki_r, kd_r;
  logic                integ_on_r;
  logic [W-2:0]        limit_r;

  // controller state
  logic signed [W-1:0] last_error_r;
  logic signed [W-1:0] last_drive_r;
  logic signed [W-1:0] integ_sum_r;
  logic                first_step_r;
  clamp_stat_t         clamp_status_r;

  // current request and work registers
  state_t              state_r;
  op_t                 op_r;
  logic signed [W-1:0] err_r;
  logic [W-1:0]        dt_r;
  logic                deriv_on_r;
  logic                div_have_r;
  logic signed [W-1:0] drive_r;

  // unit launch registers
  mul_ctl_t            mul_ctl_r;
  logic signed [W-1:0] mul_a_r;
  logic [W-1:0]        mul_b_r;
  div_ctl_t            div_ctl_r;
  logic [W-1:0]        div_num_r;

  // output register
  logic                out_valid_r;
  logic signed [W-1:0] out_drive_r;
  clamp_stat_t         out_status_r;

  unit_stat_t          mul_stat, div_stat;
  logic signed [W-1:0] mul_res, div_res;

  logic signed [W-1:0] diff;
  logic [W-1:0]        diff_mag;
  logic [W-1:0]        emag;
  logic signed [W-1:0] lim_s, neg_lim;
  logic signed [W-1:0] clamped;
  clamp_stat_t         clamp_nxt;
  logic                zero_integ;
  logic signed [W-1:0] integ_sum_nxt;
  logic                in_fire;
  logic                out_free;

  // saturating add and subtract on signed words
  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) begin
      return s[W] ? MIN_V : MAX_V;
    end
    return $signed(s[W-1:0]);
  endfunction

  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
    logic [W:0] s;
    s = {x[W-1], x} - {y[W-1], y};
    if (s[W] != s[W-1]) begin
      return s[W] ? MIN_V : MAX_V;
    end
    return $signed(s[W-1:0]);
  endfunction

  // arithmetic units
  pidc_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mul_ctl_r),
    .a      (mul_a_r),
    .b      (mul_b_r),
    .stat   (mul_stat),
    .result (mul_res)
  );

  pidc_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (div_ctl_r),
    .num    (div_num_r),
    .den    (dt_r),
    .stat   (div_stat),
    .result (div_res)
  );

  // handshakes
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;

  // change in error for the derivative
  assign diff     = sat_sub(err_r, last_error_r);
  assign diff_mag = diff[W-1] ? W'(-diff) : W'(diff);

  // integral clamp to the symmetric limit
  assign lim_s   = $signed({1'b0, limit_r});
  assign neg_lim = -lim_s;
  always_comb begin
    if (integ_sum_r > lim_s) begin
      clamped   = lim_s;
      clamp_nxt = ST_HIGH;
    end else if (integ_sum_r < neg_lim) begin
      clamped   = neg_lim;
      clamp_nxt = ST_LOW;
    end else begin
      clamped   = integ_sum_r;
      clamp_nxt = ST_OK;
    end
  end

  // anti-windup: integral against the error, or error outside the band
  assign emag = err_r[W-1] ? W'(-err_r) : W'(err_r);
  assign zero_integ = (!clamped[W-1] && (clamped != '0) && err_r[W-1]) ||
                      (clamped[W-1] && !err_r[W-1] && (err_r > EPS_Q)) ||
                      (emag > BAND_HIGH) || (emag < BAND_LOW);
  assign integ_sum_nxt = zero_integ ? '0 : clamped;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= '0;
      ki_r       <= '0;
      kd_r       <= '0;
      integ_on_r <= 1'b0;
      limit_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP:       kp_r       <= $signed(cfg_data);
        REG_KI:       ki_r       <= $signed(cfg_data);
        REG_KD:       kd_r       <= $signed(cfg_data);
        REG_INTEG_ON: integ_on_r <= cfg_data[0];
        REG_LIMIT:    limit_r    <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      last_error_r   <= '0;
      last_drive_r   <= '0;
      integ_sum_r    <= '0;
      first_step_r   <= 1'b1;
      clamp_status_r <= ST_OK;
      div_have_r     <= 1'b0;
      mul_ctl_r      <= '0;
      div_ctl_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // launch pulses last one cycle; no launch follows another directly
      if (mul_ctl_r.start) begin
        mul_ctl_r.start <= 1'b0;
      end
      if (div_ctl_r.start) begin
        div_ctl_r.start <= 1'b0;
      end
      if (out_valid_r && out_chan.ready && (state_r != S_PUT)) begin
        out_valid_r <= 1'b0;
      end
      if (div_stat.done) begin
        div_have_r <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= op_t'(in_chan.operation);
            err_r   <= in_chan.error_value;
            dt_r    <= in_chan.time_step;
            state_r <= S_LAUNCH;
          end
        end

        S_LAUNCH: begin
          div_have_r <= 1'b0;
          if (op_r == OP_CLEAR) begin
            last_error_r   <= '0;
            integ_sum_r    <= '0;
            first_step_r   <= 1'b1;
            clamp_status_r <= ST_OK;
            drive_r        <= '0;
            state_r        <= S_PUT;
          end else if (dt_r == '0) begin
            drive_r <= last_drive_r;
            state_r <= S_PUT;
          end else begin
            first_step_r <= 1'b0;
            deriv_on_r   <= !first_step_r;
            last_error_r <= err_r;
            if (!first_step_r) begin
              div_ctl_r.start <= 1'b1;
              div_ctl_r.neg   <= diff[W-1];
              div_num_r       <= diff_mag;
            end
            mul_ctl_r.start <= 1'b1;
            mul_a_r         <= err_r;
            if (integ_on_r) begin
              mul_b_r            <= dt_r;
              mul_ctl_r.b_signed <= 1'b0;
              state_r            <= S_EDT;
            end else begin
              integ_sum_r        <= '0;
              mul_b_r            <= kp_r;
              mul_ctl_r.b_signed <= 1'b1;
              state_r            <= S_KP;
            end
          end
        end

        // error times time step, then times integral gain
        S_EDT: begin
          if (mul_stat.done) begin
            mul_ctl_r.start    <= 1'b1;
            mul_ctl_r.b_signed <= 1'b1;
            mul_a_r            <= mul_res;
            mul_b_r            <= ki_r;
            state_r            <= S_KI;
          end
        end

        S_KI: begin
          if (mul_stat.done) begin
            integ_sum_r <= sat_add(integ_sum_r, mul_res);
            state_r     <= S_CLAMP;
          end
        end

        S_CLAMP: begin
          integ_sum_r        <= integ_sum_nxt;
          clamp_status_r     <= clamp_nxt;
          mul_ctl_r.start    <= 1'b1;
          mul_ctl_r.b_signed <= 1'b1;
          mul_a_r            <= err_r;
          mul_b_r            <= kp_r;
          state_r            <= S_KP;
        end

        // proportional term plus integral
        S_KP: begin
          if (mul_stat.done) begin
            drive_r <= sat_add(mul_res, integ_sum_r);
            state_r <= S_WAIT_DIV;
          end
        end

        // derivative term once the quotient is in
        S_WAIT_DIV: begin
          if (!deriv_on_r) begin
            state_r <= S_PUT;
          end else if (div_have_r || div_stat.done) begin
            mul_ctl_r.start    <= 1'b1;
            mul_ctl_r.b_signed <= 1'b1;
            mul_a_r            <= div_res;
            mul_b_r            <= kd_r;
            state_r            <= S_KD;
          end
        end

        S_KD: begin
          if (mul_stat.done) begin
            drive_r <= sat_add(drive_r, mul_res);
            state_r <= S_PUT;
          end
        end

        // hand the result to the output register
        S_PUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_drive_r  <= drive_r;
            out_status_r <= clamp_status_r;
            last_drive_r <= drive_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.drive_value     = out_drive_r;
  assign out_chan.integral_status = out_status_r;

  `PIDC_ASSERT_NEXT(a_accept_launch, in_fire, state_r == S_LAUNCH, "accepted request not launched")
  `PIDC_ASSERT_NOW(a_mul_free, mul_ctl_r.start, !mul_stat.busy, "multiplier launched while busy")
  `PIDC_ASSERT_NOW(a_div_free, div_ctl_r.start, !div_stat.busy, "divider launched while busy")
  `PIDC_ASSERT_NEXT(a_clamp_bound, state_r == S_CLAMP,
                    (integ_sum_r <= $past(lim_s)) && (integ_sum_r >= $past(neg_lim)),
                    "integral left the clamp range")

endmodule

>>> bench/pidc_drive_check.sv
// ----------------------------------------------------------------------------
// pidc_drive_check
// watches the request, result and register ports of the pid step block,
// predicts each drive value and clamp status, and compares them in order
// ----------------------------------------------------------------------------
module pidc_drive_check
  import pidc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  pidc_in_if                   in_mon,
  pidc_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC     = 16;
  localparam longint UNIT     = longint'(1) << FRAC;      // 1.0
  localparam longint BAND_LO  = (UNIT * 5 + 99) / 100;    // 0.05 rounded up
  localparam longint EPS_Q    = UNIT / 1000000;           // 1e-6, zero at 16 bits
  localparam longint WORD_MAX = (longint'(1) << 31) - 1;
  localparam longint WORD_MIN = -(longint'(1) << 31);

  typedef struct packed {
    logic [31:0] drive;
    clamp_stat_t status;
  } pid_result_t;

  // register copy
  longint      kp_q, ki_q, kd_q, limit_q;
  logic        integ_en;

  // controller state copy
  longint      prev_err, held_drive, integ_acc;
  logic        fresh;
  clamp_stat_t held_stat;

  pid_result_t expected_q[$];

  function automatic longint sat_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // q16.16 product, magnitude truncated toward zero
  function automatic longint qmul(longint a, longint b);
    return sat_word((a * b) / UNIT);
  endfunction

  function automatic void clear_ctrl();
    prev_err   = 0;
    held_drive = 0;
    integ_acc  = 0;
    fresh      = 1'b1;
    held_stat  = ST_OK;
  endfunction

  // one request in, one drive result out
  function automatic pid_result_t next_drive(op_t op, longint e, longint dt_q);
    pid_result_t r;
    longint      slope, mag, drv;
    slope = 0;
    if (op == OP_CLEAR) begin
      clear_ctrl();
      r.drive  = '0;
      r.status = ST_OK;
      return r;
    end
    // zero time step replays the last result
    if (dt_q == 0) begin
      r.drive  = held_drive[31:0];
      r.status = held_stat;
      return r;
    end

    // derivative, skipped on the first step
    if (fresh) begin
      fresh = 1'b0;
    end else begin
      slope = sat_word((sat_word(e - prev_err) * UNIT) / dt_q);
    end

    // integrate and clamp
    if (!integ_en) begin
      integ_acc = 0;
    end else begin
      integ_acc = sat_word(integ_acc + qmul(qmul(e, dt_q), ki_q));
      if (integ_acc > limit_q) begin
        integ_acc = limit_q;
        held_stat = ST_HIGH;
      end else if (integ_acc < -limit_q) begin
        integ_acc = -limit_q;
        held_stat = ST_LOW;
      end else begin
        held_stat = ST_OK;
      end
    end

    // anti-windup: opposing sign or error outside the band
    mag = (e < 0) ? -e : e;
    if (integ_acc > 0 && e < 0) integ_acc = 0;
    if (integ_acc < 0 && e > EPS_Q) integ_acc = 0;
    if (mag > UNIT || mag < BAND_LO) integ_acc = 0;

    prev_err   = e;
    drv        = sat_word(qmul(e, kp_q) + integ_acc);
    drv        = sat_word(drv + qmul(slope, kd_q));
    held_drive = drv;
    r.drive    = drv[31:0];
    r.status   = held_stat;
    return r;
  endfunction

  always @(posedge clk) begin
    pid_result_t want;
    if (!rst_n) begin
      kp_q       = 0;
      ki_q       = 0;
      kd_q       = 0;
      limit_q    = 0;
      integ_en   = 1'b0;
      fail_count = 0;
      clear_ctrl();
      expected_q.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no request outstanding: drive_value %0d",
                 $signed(out_mon.drive_value));
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.drive_value !== want.drive) begin
            $error("drive_value: expected %0d, actual %0d",
                   $signed(want.drive), $signed(out_mon.drive_value));
            fail_count++;
          end
          if (out_mon.integral_status !== want.status) begin
            $error("integral_status: expected %0d, actual %0d",
                   want.status, out_mon.integral_status);
            fail_count++;
          end
        end
      end

      // request transaction
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(next_drive(op_t'(in_mon.operation),
                                        longint'($signed(in_mon.error_value)),
                                        longint'({32'd0, in_mon.time_step})));
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:       kp_q     = longint'($signed(cfg_data));
          REG_KI:       ki_q     = longint'($signed(cfg_data));
          REG_KD:       kd_q     = longint'($signed(cfg_data));
          REG_INTEG_ON: integ_en = cfg_data[0];
          REG_LIMIT:    limit_q  = longint'({33'd0, cfg_data[30:0]});
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> bench/tb_pid_step_with_integrator_clamp_unit.sv
// ----------------------------------------------------------------------------
// tb_pid_step_with_integrator_clamp_unit
// drives directed and random pid step requests through several register
// settings with random gaps on both channels and long result stalls
// ----------------------------------------------------------------------------
module tb_pid_step_with_integrator_clamp_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pidc_pkg::*;

  localparam int          DW          = 32;
  localparam int          HOLD_CYCLES = 400;
  localparam int          PHASES      = 10;
  localparam int          PHASE_ITEMS = 170;
  localparam int          DRAIN_LIMIT = 20000;
  localparam int          SPARE_IDX   = int'(REG_LIMIT) + 1;
  localparam logic [31:0] ONE_Q       = 32'h0001_0000;
  localparam logic [31:0] BAND_LO_Q   = 32'd3277;
  localparam logic [31:0] POS_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX     = 32'h8000_0000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DW-1:0]        cfg_data  = '0;
  logic                 calm      = 1'b0;
  int                   hold_ticket = 0;
  int                   fail_count, pending;
  logic [31:0]          walk_err  = '0;

  pidc_in_if  #(.DATA_WIDTH(DW)) in_chan ();
  pidc_out_if #(.DATA_WIDTH(DW)) out_chan ();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pid_step_with_integrator_clamp_unit #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (16)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pidc_drive_check i_drive_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // value helpers
  function automatic logic [31:0] pick_signed(logic [31:0] span);
    logic [31:0] m;
    m = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? POS_MAX : NEG_MAX;
      default: return pick_signed(32'h0003_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return '0;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  // often inside the integration band, otherwise walks, noise, corners and wider values
  function automatic logic [31:0] pick_error();
    logic [31:0] e;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        e = $urandom_range(BAND_LO_Q, ONE_Q);
        if ($urandom_range(0, 1)) e = -e;
      end
      4: e = walk_err + pick_signed(32'h0000_2000);
      5: e = pick_signed(BAND_LO_Q - 1);
      6: e = $urandom();
      7: begin
        case ($urandom_range(0, 6))
          0:       e = NEG_MAX;
          1:       e = POS_MAX;
          2:       e = 32'd1;
          3:       e = BAND_LO_Q - 1;
          4:       e = BAND_LO_Q;
          5:       e = ONE_Q + 1;
          default: e = ONE_Q;
        endcase
        if ($urandom_range(0, 1)) e = -e;
      end
      default: e = pick_signed(32'h0004_0000);
    endcase
    walk_err = e;
    return e;
  endfunction

  function automatic logic [31:0] pick_dt();
    case ($urandom_range(0, 19))
      0:          return '0;
      1:          return $urandom();
      2: begin
        case ($urandom_range(0, 2))
          0:       return 32'd1;
          1:       return ONE_Q;
          default: return 32'hffff_ffff;
        endcase
      end
      3, 4, 5, 6: return $urandom_range(1, 32'h0000_0400);
      default:    return $urandom_range(1, 32'h0002_0000);
    endcase
  endfunction

  // one request transaction, entered and left at a falling edge
  task automatic push_request(op_t op, logic [31:0] err, logic [31:0] dt);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.operation   <= op;
    in_chan.error_value <= err;
    in_chan.time_step   <= dt;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every result, then let the block settle
  task automatic quiesce();
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic load_setting(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                              logic [31:0] on, logic [31:0] lim);
    quiesce();
    set_reg(REG_KP, kp);
    set_reg(REG_KI, ki);
    set_reg(REG_KD, kd);
    set_reg(REG_INTEG_ON, on);
    set_reg(REG_LIMIT, lim);
    // writes to unused indexes must be dropped
    set_reg(CFG_IDX_W'(SPARE_IDX + $urandom_range(0, 2)), $urandom());
  endtask

  // result side: random stalls, calm stretch, long hold-off on request
  initial begin
    int hold_served;
    hold_served    = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ticket != hold_served) begin
        hold_served++;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 99) < 14) begin
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int ph, i, n;
    in_chan.valid       = 1'b0;
    in_chan.operation   = OP_STEP;
    in_chan.error_value = '0;
    in_chan.time_step   = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // gains still zero out of reset
    push_request(OP_STEP, 32'h0001_2345, ONE_Q);
    push_request(OP_STEP, 32'hffff_8000, 32'h0000_8000);

    load_setting(ONE_Q, 32'h0002_0000, 32'h0000_8000, 32'h1, 32'h0001_8000);
    push_request(OP_CLEAR, $urandom(), $urandom());
    push_request(OP_STEP, 32'h0000_8000, ONE_Q);       // first step, no derivative
    push_request(OP_STEP, $urandom(), '0);             // zero dt replays last drive
    push_request(OP_STEP, 32'h0000_c000, ONE_Q);
    push_request(OP_STEP, 32'h0000_c000, 32'h0008_0000); // integral clamps high
    push_request(OP_STEP, -ONE_Q, 32'h0008_0000);      // opposing sign
    push_request(OP_STEP, -ONE_Q, 32'h0008_0000);      // integral clamps low
    push_request(OP_STEP, ONE_Q + 1, ONE_Q);           // above the band
    push_request(OP_STEP, BAND_LO_Q - 1, ONE_Q);       // just below the band
    push_request(OP_STEP, BAND_LO_Q, ONE_Q);
    push_request(OP_STEP, 32'h0000_0001, ONE_Q);
    push_request(OP_STEP, 32'hffff_ffff, ONE_Q);
    push_request(OP_STEP, POS_MAX, 32'hffff_ffff);
    push_request(OP_STEP, NEG_MAX, 32'h0000_0001);     // derivative saturates
    push_request(OP_STEP, 32'h0000_0000, 32'h0000_0001);
    push_request(OP_CLEAR, $urandom(), $urandom());
    push_request(OP_STEP, $urandom(), '0);             // zero dt keeps first step
    push_request(OP_STEP, 32'h0000_4000, ONE_Q);
    push_request(OP_STEP, 32'h0000_6000, ONE_Q);

    // integrator disabled keeps the stored status
    load_setting(ONE_Q, 32'h0002_0000, 32'h0000_8000, 32'hffff_fffe, 32'h0001_8000);
    push_request(OP_STEP, 32'h0000_8000, ONE_Q);
    push_request(OP_STEP, 32'h0000_9000, ONE_Q);

    // random phases over several register settings
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 1)
        load_setting(POS_MAX, POS_MAX, POS_MAX, 32'hffff_ffff, 32'hffff_ffff);
      else if (ph == 2)
        load_setting(NEG_MAX, NEG_MAX, NEG_MAX, 32'h0000_0001, '0);
      else if (ph == 4)
        load_setting(pick_gain(), pick_gain(), pick_gain(),
                     {31'($urandom_range(0, 32'h7fff_ffff)), 1'b0}, pick_limit());
      else
        load_setting(pick_gain(), pick_gain(), pick_gain(),
                     {31'($urandom_range(0, 32'h7fff_ffff)),
                      1'($urandom_range(0, 4) != 0)},
                     pick_limit());
      calm <= (ph == 5);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ((ph == 3 || ph == 7) && i == 40) hold_ticket <= hold_ticket + 1;
        if ($urandom_range(0, 99) < 3)
          push_request(OP_CLEAR, $urandom(), $urandom());
        else
          push_request(OP_STEP, pick_error(), pick_dt());
      end
    end

    // drain
    in_chan.valid <= 1'b0;
    for (n = 0; n < DRAIN_LIMIT && pending != 0; n++) @(negedge clk);
    repeat (80) @(negedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> pid_step_with_integrator_clamp_unit.f
+incdir+rtl/core
rtl/core/pidc_pkg.sv
rtl/core/pidc_if.sv
rtl/core/pidc_mul.sv
rtl/core/pidc_div.sv
rtl/core/pid_step_with_integrator_clamp_unit.sv
bench/pidc_drive_check.sv
bench/tb_pid_step_with_integrator_clamp_unit.sv
